[src/sob_pkg.sv]
// Shared constants, payload types and the divide-by-255 helper for the
// source-over straight-alpha blend pipeline. No dependencies.
package sob_pkg;

  localparam int NUM_STAGES = 9;
  localparam int NUM_CHAN = 3;

  localparam logic [7:0] FULL_VALUE = 8'd255;
  localparam logic [16:0] RND_HALF = 17'd127;
  // ceil(2^23 / 255); exact floor(x / 255) for x below 65536
  localparam logic [15:0] RECIP255 = 16'd32897;
  localparam int RECIP_SHIFT = 23;

  typedef enum logic [1:0] {
    MODE_KEEP_DST,
    MODE_SRC_FULL,
    MODE_SRC_EFF,
    MODE_BLEND
  } mode_t;

  typedef struct packed {
    logic [NUM_CHAN-1:0][7:0] src_rgb;
    logic [7:0] src_a;
    logic [7:0] cov;
    logic [NUM_CHAN-1:0][7:0] dst_rgb;
    logic [7:0] dst_a;
  } pix_t;

  // Side data that rides along with each word down the pipe.
  typedef struct packed {
    pix_t pix;
    mode_t mode;
    logic [7:0] eff;
    logic [7:0] back;
    logic [8:0] oa;
  } stg_t;

  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [32:0] m;
    m = 33'(x) * 33'(RECIP255);
    return m[RECIP_SHIFT +: 8];
  endfunction

endpackage

[src/src_over_straight_alpha_blend_top.sv]
// Source-over compositing of one pixel onto a straight-alpha destination.
// Depends on sob_pkg and sob_divstep.
//
//   channel   direction   handshake            payload
//   in        into block  in_valid / in_stall  src_red..dst_alpha, 8 bits each
//   out       from block  out_valid/out_stall  out_red..out_alpha, 8 bits each
//
// Nine register stages: alpha product, effective alpha, surviving destination
// alpha (two stages), weighted sums, then four stages of two quotient bits each.
// One word enters per clock while in_stall is low.
// rst clears only the stage valid bits. A stall at the output holds the last
// stage; earlier stages keep moving into empty slots, so bubbles collapse.
module src_over_straight_alpha_blend_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] src_red,
  input  logic [7:0] src_green,
  input  logic [7:0] src_blue,
  input  logic [7:0] src_alpha,
  input  logic [7:0] coverage,
  input  logic [7:0] dst_red,
  input  logic [7:0] dst_green,
  input  logic [7:0] dst_blue,
  input  logic [7:0] dst_alpha,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);
  import sob_pkg::*;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_next;
  logic [NUM_STAGES-1:0] en;

  stg_t        stg [0:NUM_STAGES-2];
  stg_t        stg_in;
  stg_t        stg1_next;
  stg_t        stg3_next;
  stg_t        stg4_next;
  logic [15:0] prod0;
  logic [7:0]  eff_next;
  logic [16:0] t2;
  logic [16:0] num4 [NUM_CHAN];
  logic [16:0] num4_next [NUM_CHAN];
  logic [16:0] drem [1:3][NUM_CHAN];
  logic [7:0]  dquo [1:3][NUM_CHAN];
  logic [16:0] step_rem [0:3][NUM_CHAN];
  logic [7:0]  step_quo [0:3][NUM_CHAN];
  logic [NUM_CHAN-1:0][7:0] rgb_sel;
  logic [7:0]  a_sel;

  // ---- flow control ----
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
    vld_next[0] = en[0] ? in_valid : vld[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_next[k] = en[k] ? vld[k-1] : vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_stall = !en[0];
  assign out_valid = vld[NUM_STAGES-1];

  // ---- stage 0: alpha times coverage ----
  always_comb begin
    stg_in = '0;
    stg_in.pix.src_rgb = {src_blue, src_green, src_red};
    stg_in.pix.src_a = src_alpha;
    stg_in.pix.cov = coverage;
    stg_in.pix.dst_rgb = {dst_blue, dst_green, dst_red};
    stg_in.pix.dst_a = dst_alpha;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      stg[0] <= stg_in;
      prod0 <= 16'(src_alpha) * 16'(coverage);
    end
  end

  // ---- stage 1: effective alpha and path choice ----
  always_comb begin
    eff_next = div255({1'b0, prod0} + RND_HALF);
    stg1_next = stg[0];
    stg1_next.eff = eff_next;
    priority if (eff_next == '0) begin
      stg1_next.mode = MODE_KEEP_DST;
    end else if (eff_next == FULL_VALUE) begin
      stg1_next.mode = MODE_SRC_FULL;
    end else if (stg[0].pix.dst_a == '0) begin
      stg1_next.mode = MODE_SRC_EFF;
    end else begin
      stg1_next.mode = MODE_BLEND;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      stg[1] <= stg1_next;
    end
  end

  // ---- stage 2: dst_alpha * (255 - eff) + 127 ----
  always_ff @(posedge clk) begin
    if (en[2]) begin
      stg[2] <= stg[1];
      t2 <= 17'(stg[1].pix.dst_a) * 17'(FULL_VALUE - stg[1].eff) + RND_HALF;
    end
  end

  // ---- stage 3: surviving destination alpha ----
  always_comb begin
    stg3_next = stg[2];
    stg3_next.back = div255(t2);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      stg[3] <= stg3_next;
    end
  end

  // ---- stage 4: weighted sums with half-alpha rounding term ----
  always_comb begin
    stg4_next = stg[3];
    stg4_next.oa = {1'b0, stg[3].eff} + {1'b0, stg[3].back};
    for (int c = 0; c < NUM_CHAN; c++) begin
      num4_next[c] = 17'(stg[3].pix.src_rgb[c]) * 17'(stg[3].eff)
                   + 17'(stg[3].pix.dst_rgb[c]) * 17'(stg[3].back)
                   + 17'(stg4_next.oa >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      stg[4] <= stg4_next;
      num4 <= num4_next;
    end
  end

  // ---- stages 5..8: quotient, two bits per stage, MSBs first ----
  // Quotient fits 8 bits since the sum stays below 256 * oa.
  for (genvar j = 0; j < 4; j++) begin : g_div
    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      if (j == 0) begin : g_first
        sob_divstep u_step (
          .rem_in  (num4[c]),
          .quo_in  (8'd0),
          .oa      (stg[4].oa),
          .pos     (2'(3 - j)),
          .rem_out (step_rem[j][c]),
          .quo_out (step_quo[j][c])
        );
      end else begin : g_next
        sob_divstep u_step (
          .rem_in  (drem[j][c]),
          .quo_in  (dquo[j][c]),
          .oa      (stg[4+j].oa),
          .pos     (2'(3 - j)),
          .rem_out (step_rem[j][c]),
          .quo_out (step_quo[j][c])
        );
      end
    end
  end

  for (genvar j = 1; j < 4; j++) begin : g_dreg
    always_ff @(posedge clk) begin
      if (en[4+j]) begin
        stg[4+j] <= stg[3+j];
        for (int c = 0; c < NUM_CHAN; c++) begin
          drem[j][c] <= step_rem[j-1][c];
          dquo[j][c] <= step_quo[j-1][c];
        end
      end
    end
  end

  // ---- stage 8: pick the result for the path, register to ports ----
  always_comb begin
    unique case (stg[7].mode)
      MODE_KEEP_DST: begin
        rgb_sel = stg[7].pix.dst_rgb;
        a_sel = stg[7].pix.dst_a;
      end
      MODE_SRC_FULL: begin
        rgb_sel = stg[7].pix.src_rgb;
        a_sel = FULL_VALUE;
      end
      MODE_SRC_EFF: begin
        rgb_sel = stg[7].pix.src_rgb;
        a_sel = stg[7].eff;
      end
      MODE_BLEND: begin
        for (int c = 0; c < NUM_CHAN; c++) begin
          rgb_sel[c] = step_quo[3][c];
        end
        a_sel = stg[7].oa[8] ? FULL_VALUE : stg[7].oa[7:0];
      end
      default: begin
        rgb_sel = stg[7].pix.dst_rgb;
        a_sel = stg[7].pix.dst_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      out_red <= rgb_sel[0];
      out_green <= rgb_sel[1];
      out_blue <= rgb_sel[2];
      out_alpha <= a_sel;
    end
  end

endmodule

[src/sob_divstep.sv]
// Two restoring division steps for one colour channel (two quotient bits).
// Depends on nothing beyond plain logic; used by the blend top level.
module sob_divstep (
  input  logic [16:0] rem_in,
  input  logic [7:0]  quo_in,
  input  logic [8:0]  oa,
  input  logic [1:0]  pos,
  output logic [16:0] rem_out,
  output logic [7:0]  quo_out
);

  logic [2:0]  hi_bit;
  logic [2:0]  lo_bit;
  logic [16:0] d_hi;
  logic [16:0] d_lo;
  logic [16:0] rem_mid;

  always_comb begin
    hi_bit = {pos, 1'b1};
    lo_bit = {pos, 1'b0};
    d_hi = 17'(oa) << hi_bit;
    d_lo = 17'(oa) << lo_bit;
    quo_out = quo_in;
    if (rem_in >= d_hi) begin
      rem_mid = rem_in - d_hi;
      quo_out[hi_bit] = 1'b1;
    end else begin
      rem_mid = rem_in;
    end
    if (rem_mid >= d_lo) begin
      rem_out = rem_mid - d_lo;
      quo_out[lo_bit] = 1'b1;
    end else begin
      rem_out = rem_mid;
    end
  end

endmodule

[src/sob_check.sv]
// Port-level checks for the blend top level, attached by bind below.
// Depends only on the top level's port names.
module sob_check (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);

  // a held word stays offered
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out word dropped while stalled");

  // a held word does not change
  a_out_stable : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_alpha))
    else $error("out word changed while stalled");

  // reset empties the pipe
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

  // input can only back up when the output holds a word
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind src_over_straight_alpha_blend_top sob_check u_sob_check (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// Testbench for src_over_straight_alpha_blend_top: directed corner pixels and random pixels
// are checked against an in-bench source-over blend predictor. Depends on sob_pkg and the RTL.
module testbench;
  import sob_pkg::*;

  localparam int DRAIN_CYCLES = 2 * NUM_STAGES + 4;
  localparam int RANDOM_WORDS = 1300;

  typedef struct {
    logic [7:0] sr, sg, sb, sa, cov, dr, dg, db, da;
  } pixel_word_t;

  typedef struct {
    logic [7:0] red, green, blue, alpha;
    mode_t      mode;
  } blend_result_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] src_red = '0, src_green = '0, src_blue = '0, src_alpha = '0, coverage = '0;
  logic [7:0] dst_red = '0, dst_green = '0, dst_blue = '0, dst_alpha = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue, out_alpha;

  pixel_word_t   pending_pixels[$];
  blend_result_t expected_pixels[$];
  bit            word_taken;
  int            src_gap, sink_gap;
  int            words_in, words_out, error_count;
  int            mode_hits[4];
  bit            idle_on;

  src_over_straight_alpha_blend_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bursts of idling early on, a quiet stretch in the middle, none at the tail
  assign idle_on = (words_in < 950) && !(words_in >= 350 && words_in < 500);

  function automatic logic [7:0] blend_channel(int unsigned s, int unsigned d,
                                               int unsigned eff, int unsigned back,
                                               int unsigned oa);
    int unsigned v;
    v = (s * eff + d * back + oa / 2) / oa;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic blend_result_t composite_pixel(pixel_word_t p);
    int unsigned eff, back, oa;
    blend_result_t r;
    eff = (int'(p.sa) * int'(p.cov) + 127) / 255;
    if (eff == 0) begin
      r = '{p.dr, p.dg, p.db, p.da, MODE_KEEP_DST};
    end else if (eff >= 255) begin
      r = '{p.sr, p.sg, p.sb, 8'd255, MODE_SRC_FULL};
    end else if (p.da == 8'd0) begin
      r = '{p.sr, p.sg, p.sb, eff[7:0], MODE_SRC_EFF};
    end else begin
      back = (int'(p.da) * (255 - eff) + 127) / 255;
      oa = eff + back;
      r.red   = blend_channel(p.sr, p.dr, eff, back, oa);
      r.green = blend_channel(p.sg, p.dg, eff, back, oa);
      r.blue  = blend_channel(p.sb, p.db, eff, back, oa);
      r.alpha = (oa > 255) ? 8'd255 : oa[7:0];
      r.mode  = MODE_BLEND;
    end
    return r;
  endfunction

  // edge-heavy byte so alpha and coverage hit the special cases often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 3));
      3: return 8'($urandom_range(252, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_pixel(logic [7:0] sr, sg, sb, sa, cov, dr, dg, db, da);
    pending_pixels.push_back('{sr, sg, sb, sa, cov, dr, dg, db, da});
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // source side: next word goes out on the falling edge after the last was taken, unless an idle gap is running
  always @(negedge clk) begin
    pixel_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        w = pending_pixels.pop_front();
        src_red <= w.sr; src_green <= w.sg; src_blue <= w.sb; src_alpha <= w.sa;
        coverage <= w.cov;
        dst_red <= w.dr; dst_green <= w.dg; dst_blue <= w.db; dst_alpha <= w.da;
        in_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 99) < 8) src_gap = $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // sink side stall bursts
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (idle_on && $urandom_range(0, 99) < 8) sink_gap = $urandom_range(1, 19);
    end
  end

  always @(posedge clk) begin
    blend_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want = composite_pixel('{src_red, src_green, src_blue, src_alpha, coverage,
                                 dst_red, dst_green, dst_blue, dst_alpha});
        expected_pixels.push_back(want);
        mode_hits[want.mode]++;
        words_in++;
        word_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        words_out++;
        if (expected_pixels.size() == 0) begin
          $error("output word with nothing expected: %0d %0d %0d %0d",
                 out_red, out_green, out_blue, out_alpha);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_red", want.red, out_red);
          check_field("out_green", want.green, out_green);
          check_field("out_blue", want.blue, out_blue);
          check_field("out_alpha", want.alpha, out_alpha);
        end
      end
    end
  end

  initial begin
    pixel_word_t w;
    // directed corners
    add_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    add_pixel(8'd10, 8'd20, 8'd30, 8'd0, 8'd255, 8'd200, 8'd100, 8'd50, 8'd77);
    add_pixel(8'd10, 8'd20, 8'd30, 8'd255, 8'd0, 8'd1, 8'd2, 8'd3, 8'd255);
    add_pixel(8'd255, 8'd0, 8'd255, 8'd1, 8'd127, 8'd0, 8'd255, 8'd0, 8'd128);
    add_pixel(8'd1, 8'd2, 8'd3, 8'd255, 8'd255, 8'd250, 8'd251, 8'd252, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd12);
    add_pixel(8'd90, 8'd180, 8'd45, 8'd128, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255, 8'd1, 8'd1, 8'd9, 8'd8, 8'd7, 8'd0);
    add_pixel(8'd200, 8'd100, 8'd50, 8'd128, 8'd255, 8'd10, 8'd20, 8'd30, 8'd255);
    add_pixel(8'd255, 8'd0, 8'd128, 8'd1, 8'd128, 8'd0, 8'd255, 8'd127, 8'd255);
    add_pixel(8'd255, 8'd255, 8'd0, 8'd254, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255);
    add_pixel(8'd0, 8'd0, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 8'd0, 8'd1);
    add_pixel(8'd17, 8'd34, 8'd51, 8'd64, 8'd192, 8'd240, 8'd120, 8'd60, 8'd1);
    add_pixel(8'd255, 8'd255, 8'd255, 8'd2, 8'd255, 8'd0, 8'd0, 8'd0, 8'd254);
    add_pixel(8'd0, 8'd0, 8'd0, 8'd253, 8'd255, 8'd255, 8'd255, 8'd255, 8'd3);
    add_pixel(8'd128, 8'd128, 8'd128, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127);
    add_pixel(8'd85, 8'd170, 8'd255, 8'd255, 8'd128, 8'd170, 8'd85, 8'd0, 8'd200);
    // random pixels, a quarter fully uniform, the rest edge-weighted
    repeat (RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        w = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      end else begin
        w = '{pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
              pick_byte(), pick_byte(), pick_byte(), pick_byte()};
      end
      pending_pixels.push_back(w);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_pixels.size() == 0 && !in_valid && expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Blended %0d pixels in, %0d out, with %0d mismatches.",
             words_in, words_out, error_count);
    $display("Paths hit: keep dst %0d, opaque src %0d, clear dst %0d, blend %0d.",
             mode_hits[MODE_KEEP_DST], mode_hits[MODE_SRC_FULL],
             mode_hits[MODE_SRC_EFF], mode_hits[MODE_BLEND]);
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d words still expected.", expected_pixels.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
src/sob_pkg.sv
src/sob_divstep.sv
src/src_over_straight_alpha_blend_top.sv
src/sob_check.sv
tb/testbench.sv
